@@ design/pps_pkg.sv @@
package pps_pkg;

	localparam int DEF_NUM_STAGES  = 16;
	localparam int DEF_VALUE_WIDTH = 16;
	localparam int PORT_WIDTH      = 16;

	typedef struct packed {
		logic take_item;
		logic rd_en;
		logic survive;
		logic ins_write;
		logic div_start;
		logic div_step;
		logic idx_next;
		logic out_load;
		logic cnt_clear;
	} cmd_t;

	typedef struct packed {
		logic small_value;
		logic eos;
		logic at_count;
		logic full;
		logic div_done;
		logic divides;
		logic out_free;
	} sts_t;

endpackage

@@ design/pps_ctrl.sv @@
module pps_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cand_valid,
	output logic          cand_ready,
	input  pps_pkg::sts_t sts,
	output pps_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PROBE  = 3'd1;
	localparam logic [2:0] ST_LOAD   = 3'd2;
	localparam logic [2:0] ST_DIVIDE = 3'd3;
	localparam logic [2:0] ST_CHECK  = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign cand_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (cand_valid) begin
					cmd.take_item = 1'b1;
					state_d       = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (sts.small_value) begin
					cmd.cnt_clear = sts.eos;
					state_d       = ST_IDLE;
				end else if (sts.at_count) begin
					cmd.survive   = 1'b1;
					cmd.ins_write = !sts.full;
					state_d       = ST_EMIT;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.divides) begin
					cmd.cnt_clear = sts.eos;
					state_d       = ST_IDLE;
				end else begin
					cmd.idx_next = 1'b1;
					state_d      = ST_PROBE;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load  = 1'b1;
					cmd.cnt_clear = sts.eos;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ design/pps_datapath.sv @@
module pps_datapath #(
	parameter int NUM_STAGES  = pps_pkg::DEF_NUM_STAGES,
	parameter int VALUE_WIDTH = pps_pkg::DEF_VALUE_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [pps_pkg::PORT_WIDTH-1:0]    value,
	input  logic                              end_of_stream,
	input  pps_pkg::cmd_t                     cmd,
	output pps_pkg::sts_t                     sts,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [pps_pkg::PORT_WIDTH-1:0]    prime_value,
	output logic                              no_free_stage
);

	localparam int AW = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
	localparam int CW = $clog2(NUM_STAGES + 1);
	localparam int SW = $clog2(VALUE_WIDTH);

	logic [VALUE_WIDTH-1:0] mem [NUM_STAGES];
	logic [VALUE_WIDTH-1:0] rdata_q;

	logic [VALUE_WIDTH-1:0] v_q;
	logic                   eos_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          idx_q;
	logic                   flag_q;

	logic [VALUE_WIDTH-1:0] d_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [SW-1:0]          step_q;
	logic [VALUE_WIDTH:0]   partial;
	logic [VALUE_WIDTH:0]   diff;

	logic                          res_valid_q;
	logic [pps_pkg::PORT_WIDTH-1:0] res_value_q;
	logic                          res_flag_q;

	assign partial = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign diff    = partial - {1'b0, d_q};

	assign sts.small_value = (v_q < VALUE_WIDTH'(2));
	assign sts.eos         = eos_q;
	assign sts.at_count    = (idx_q == cnt_q);
	assign sts.full        = (cnt_q == CW'(NUM_STAGES));
	assign sts.div_done    = (step_q == SW'(VALUE_WIDTH - 1));
	assign sts.divides     = (rem_q == '0) && (d_q != '0);
	assign sts.out_free    = !res_valid_q || res_ready;

	always_ff @(posedge clk) begin
		if (cmd.ins_write) begin
			mem[cnt_q[AW-1:0]] <= v_q;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			v_q   <= VALUE_WIDTH'(value);
			eos_q <= end_of_stream;
		end
		if (cmd.survive) begin
			flag_q <= sts.full;
		end
		if (cmd.div_start) begin
			d_q    <= rdata_q;
			rem_q  <= '0;
			quo_q  <= v_q;
			step_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= diff[VALUE_WIDTH] ? partial[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
			quo_q  <= {quo_q[VALUE_WIDTH-2:0], 1'b0};
			step_q <= step_q + SW'(1);
		end
		if (cmd.out_load) begin
			res_value_q <= pps_pkg::PORT_WIDTH'(v_q);
			res_flag_q  <= flag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_clear) begin
				cnt_q <= '0;
			end else if (cmd.ins_write) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.take_item) begin
				idx_q <= '0;
			end else if (cmd.idx_next) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid     = res_valid_q;
	assign prime_value   = res_value_q;
	assign no_free_stage = res_flag_q;

endmodule

@@ design/pipelined_prime_sieve.sv @@
// Channel    Handshake                 Payload
// cand       cand_valid / cand_ready   value, end_of_stream
// res        res_valid / res_ready     prime_value, no_free_stage
//
// One candidate is handled at a time. Each occupied stage that is tested goes through the
// registered stage memory read and then the bit-serial remainder unit. Stages fill in
// order, so a fill count marks which ones are occupied and reset needs no clearing pass.
// The result register lets a candidate be accepted while a result waits; a survivor
// stalls only when that register is still full.
module pipelined_prime_sieve #(
	parameter int NUM_STAGES  = pps_pkg::DEF_NUM_STAGES,
	parameter int VALUE_WIDTH = pps_pkg::DEF_VALUE_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cand_valid,
	output logic                           cand_ready,
	input  logic [pps_pkg::PORT_WIDTH-1:0] value,
	input  logic                           end_of_stream,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic [pps_pkg::PORT_WIDTH-1:0] prime_value,
	output logic                           no_free_stage
);

	pps_pkg::cmd_t cmd;
	pps_pkg::sts_t sts;

	pps_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cand_valid (cand_valid),
		.cand_ready (cand_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	pps_datapath #(
		.NUM_STAGES  (NUM_STAGES),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.value         (value),
		.end_of_stream (end_of_stream),
		.cmd           (cmd),
		.sts           (sts),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.prime_value   (prime_value),
		.no_free_stage (no_free_stage)
	);

endmodule

@@ verif/pipelined_prime_sieve_test.sv @@
`timescale 1ns / 100ps

module pipelined_prime_sieve_test;

	localparam int STAGES      = pps_pkg::DEF_NUM_STAGES;
	localparam int HOLD_CYCLES = 800;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 400;

	typedef struct packed {
		logic [pps_pkg::PORT_WIDTH-1:0] value;
		logic                           eos;
	} candidate_t;

	typedef struct packed {
		logic [pps_pkg::PORT_WIDTH-1:0] prime_value;
		logic                           no_free_stage;
	} prime_out_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cand_valid = 1'b0;
	logic                           cand_ready;
	logic [pps_pkg::PORT_WIDTH-1:0] value = '0;
	logic                           end_of_stream = 1'b0;
	logic                           res_valid;
	logic                           res_ready = 1'b0;
	logic [pps_pkg::PORT_WIDTH-1:0] prime_value;
	logic                           no_free_stage;

	candidate_t            pending_cands[$];
	prime_out_t            expected_primes[$];

	logic [pps_pkg::PORT_WIDTH-1:0] sieve_prime[STAGES];
	bit                             sieve_full[STAGES];

	int                    send_idle_pct = 24;
	int                    recv_idle_pct = 76;
	int                    error_count = 0;
	int                    stall_cycles = 0;
	int                    hold_left = 0;
	bit                    hold_req = 1'b0;
	bit                    hold_done = 1'b0;

	pipelined_prime_sieve dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cand_valid   (cand_valid),
		.cand_ready   (cand_ready),
		.value        (value),
		.end_of_stream(end_of_stream),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.prime_value  (prime_value),
		.no_free_stage(no_free_stage)
	);

	always #1 clk = ~clk;

	function automatic void clear_sieve();
		int i;
		for (i = 0; i < STAGES; i++) begin
			sieve_prime[i] = '0;
			sieve_full[i]  = 1'b0;
		end
	endfunction

	function automatic bit sieve_candidate(input candidate_t cand, output prime_out_t res);
		int i;
		bit emitted;
		emitted = 1'b0;
		res = '0;
		if (cand.value >= 2) begin
			emitted = 1'b1;
			res.prime_value = cand.value;
			res.no_free_stage = 1'b1;
			for (i = 0; i < STAGES; i++) begin
				if (!sieve_full[i]) begin
					sieve_prime[i] = cand.value;
					sieve_full[i] = 1'b1;
					res.no_free_stage = 1'b0;
					break;
				end
				if (sieve_prime[i] != 0 && (cand.value % sieve_prime[i]) == 0) begin
					emitted = 1'b0;
					break;
				end
			end
		end
		if (cand.eos)
			clear_sieve();
		return emitted;
	endfunction

	function automatic void push_cand(input int unsigned v, input bit eos);
		candidate_t c;
		c.value = v[pps_pkg::PORT_WIDTH-1:0];
		c.eos = eos;
		pending_cands.push_back(c);
	endfunction

	task automatic add_random_cands(input int count);
		int added;
		int unsigned kind;
		int unsigned len;
		int unsigned base;
		int unsigned v;
		int j;
		added = 0;
		while (added < count) begin
			kind = $urandom_range(0, 9);
			if (kind <= 6) begin
				base = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 65535 - 80) : 2;
				len = $urandom_range(1, 70);
				for (j = 0; j < len; j++)
					push_cand(base + j, j == len - 1);
				added += len;
			end else if (kind == 7) begin
				push_cand($urandom_range(0, 65535), $urandom_range(0, 7) == 0);
				added++;
			end else if (kind == 8) begin
				push_cand($urandom_range(0, 1), $urandom_range(0, 1));
				added++;
			end else begin
				v = $urandom_range(2, 200);
				len = $urandom_range(3, 30);
				for (j = 0; j < len; j++) begin
					push_cand(v, 1'b0);
					if ($urandom_range(0, 4) == 0)
						v = $urandom_range(0, v);
					else
						v = v + $urandom_range(0, 3);
				end
				added += len;
			end
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pending_cands.size() != 0 || cand_valid || expected_primes.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin : cand_driver
		candidate_t nxt;
		candidate_t got;
		prime_out_t res;
		if (!arst_n) begin
			cand_valid <= 1'b0;
			value <= '0;
			end_of_stream <= 1'b0;
		end else begin
			if (cand_valid && cand_ready) begin
				got.value = value;
				got.eos = end_of_stream;
				if (sieve_candidate(got, res))
					expected_primes.push_back(res);
			end
			if (!cand_valid || cand_ready) begin
				if (pending_cands.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = pending_cands.pop_front();
					cand_valid <= 1'b1;
					value <= nxt.value;
					end_of_stream <= nxt.eos;
				end else begin
					cand_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : res_monitor
		prime_out_t exp_res;
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				if (expected_primes.size() == 0) begin
					$display("%0t: unexpected result prime_value %0d no_free_stage %0b",
						$time, prime_value, no_free_stage);
					error_count++;
				end else begin
					exp_res = expected_primes.pop_front();
					if (prime_value !== exp_res.prime_value) begin
						$display("%0t: prime_value expected %0d, got %0d",
							$time, exp_res.prime_value, prime_value);
						error_count++;
					end
					if (no_free_stage !== exp_res.no_free_stage) begin
						$display("%0t: no_free_stage expected %0b, got %0b (value %0d)",
							$time, exp_res.no_free_stage, no_free_stage, exp_res.prime_value);
						error_count++;
					end
				end
			end
			if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cand_valid && cand_ready) || (res_valid && res_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		clear_sieve();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Small values, a full chain, survivors past it, and clearing on a small value.
		push_cand(0, 1'b0);
		push_cand(1, 1'b0);
		push_cand(2, 1'b0);
		push_cand(3, 1'b0);
		push_cand(5, 1'b0);
		push_cand(7, 1'b0);
		push_cand(11, 1'b0);
		push_cand(13, 1'b0);
		push_cand(17, 1'b0);
		push_cand(19, 1'b0);
		push_cand(23, 1'b0);
		push_cand(29, 1'b0);
		push_cand(31, 1'b0);
		push_cand(37, 1'b0);
		push_cand(41, 1'b0);
		push_cand(43, 1'b0);
		push_cand(47, 1'b0);
		push_cand(53, 1'b0);
		push_cand(59, 1'b0);
		push_cand(65521, 1'b0);
		push_cand(4, 1'b0);
		push_cand(1, 1'b1);
		// Out-of-order candidates store a composite that later drops its own value.
		push_cand(65535, 1'b0);
		push_cand(32768, 1'b0);
		push_cand(65535, 1'b1);
		add_random_cands(480);
		wait_drained();

		send_idle_pct = 76;
		recv_idle_pct = 24;
		add_random_cands(500);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b1;
		add_random_cands(500);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_primes.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_primes.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ pipelined_prime_sieve.f @@
design/pps_pkg.sv
design/pps_ctrl.sv
design/pps_datapath.sv
design/pipelined_prime_sieve.sv
verif/pipelined_prime_sieve_test.sv
